[hdl/dfanc_pkg.sv]
package dfanc_pkg;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_EMPTY = 2'd1;
  localparam logic [1:0] ACT_TRANS = 2'd2;
  localparam logic [1:0] ACT_CLASS = 2'd3;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_EMPTY,
    OP_TRANS,
    OP_CLASS
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] symbol;
    logic       last_byte;
    logic       sym_oob;
    logic [6:0] from_state;
    logic [6:0] to_state;
    logic       push_flag;
    logic       pop_flag;
  } item_t;

endpackage

[hdl/dfanc_if.sv]
interface dfanc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] symbol;
  logic       last_byte;
  logic [6:0] from_state;
  logic [6:0] to_state;
  logic       push_flag;
  logic       pop_flag;

  modport source (
    output valid, action, symbol, last_byte, from_state, to_state, push_flag, pop_flag,
    input  ready
  );
  modport sink (
    input  valid, action, symbol, last_byte, from_state, to_state, push_flag, pop_flag,
    output ready
  );
endinterface

interface dfanc_out_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, accepted, input ready);
  modport sink (input valid, accepted, output ready);
endinterface

interface dfanc_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hdl/dfanc_front.sv]
module dfanc_front #(
  parameter int NUM_STATES = 64,
  parameter int ALPHABET   = 256
) (
  dfanc_in_if.sink              in_i,
  input  logic                  init_done_i,
  input  logic                  push_ready_i,
  output logic                  push_valid_o,
  output dfanc_pkg::item_t      push_item_o
);

  logic sym_oob;
  logic keep;

  assign sym_oob = ({1'b0, in_i.symbol} >= 9'(ALPHABET));

  always_comb begin
    push_item_o.symbol     = in_i.symbol;
    push_item_o.last_byte  = in_i.last_byte;
    push_item_o.sym_oob    = sym_oob;
    push_item_o.from_state = in_i.from_state;
    push_item_o.to_state   = in_i.to_state;
    push_item_o.push_flag  = in_i.push_flag;
    push_item_o.pop_flag   = in_i.pop_flag;
    push_item_o.op         = dfanc_pkg::OP_BYTE;
    keep                   = 1'b1;
    case (in_i.action)
      dfanc_pkg::ACT_BYTE: begin
        push_item_o.op = dfanc_pkg::OP_BYTE;
      end
      dfanc_pkg::ACT_EMPTY: begin
        push_item_o.op = dfanc_pkg::OP_EMPTY;
      end
      dfanc_pkg::ACT_TRANS: begin
        push_item_o.op = dfanc_pkg::OP_TRANS;
        keep = (in_i.from_state != 7'd0) && (in_i.from_state <= 7'(NUM_STATES)) &&
               (in_i.to_state <= 7'(NUM_STATES)) && !sym_oob;
      end
      default: begin
        push_item_o.op = dfanc_pkg::OP_CLASS;
        keep = !sym_oob;
      end
    endcase
  end

  assign in_i.ready   = init_done_i && push_ready_i;
  assign push_valid_o = in_i.valid && in_i.ready && keep;

endmodule

[hdl/dfanc_queue.sv]
module dfanc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  dfanc_pkg::item_t push_item_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output dfanc_pkg::item_t pop_item_o,
  input  logic             pop_ready_i
);

  localparam int QW = $clog2(dfanc_pkg::QUEUE_DEPTH);

  dfanc_pkg::item_t mem_q [dfanc_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QW:0]   count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q < (QW+1)'(dfanc_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? QW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? QW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hdl/dfanc_back.sv]
module dfanc_back #(
  parameter int NUM_STATES = 64,
  parameter int ALPHABET   = 256,
  parameter int MAX_DEPTH  = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  dfanc_pkg::item_t q_item_i,
  output logic             q_ready_o,
  output logic             init_done_o,
  dfanc_cfg_if.sink        cfg_i,
  dfanc_out_if.source      out_o
);

  localparam int SW = $clog2(NUM_STATES);
  localparam int AW = $clog2(ALPHABET);
  localparam int TW = SW + AW;
  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic [6:0]    tt_mem [2**TW];
  logic [1:0]    cls_mem [2**AW];

  logic [63:0]   mask_q;
  logic          init_done_q;
  logic [TW-1:0] clr_idx_q;

  logic [6:0]    tt_rdata_q;
  logic [1:0]    cls_rdata_q;

  logic             b_valid_q;
  dfanc_pkg::op_e   b_op_q;
  logic             b_last_q;
  logic             b_oob_q;

  logic [6:0]    state_q, state_d;
  logic [DW-1:0] depth_q, depth_d;
  logic          failed_q, failed_d;

  logic          out_valid_q;
  logic          out_acc_q;

  logic          a_fire, b_fire, b_emit;
  logic          tt_we, tt_re, cls_we;
  logic [TW-1:0] tt_addr;
  logic [6:0]    tt_wdata;
  logic [AW-1:0] sym_idx;

  logic [6:0]    s, s_m1;
  logic [DW-1:0] d;
  logic          f, acc;

  assign b_emit = b_valid_q && ((b_op_q == dfanc_pkg::OP_EMPTY) ||
                                ((b_op_q == dfanc_pkg::OP_BYTE) && b_last_q));
  assign b_fire = b_valid_q && (!b_emit || !out_valid_q || out_o.ready);
  assign a_fire = q_valid_i && init_done_q && (!b_valid_q || b_fire);

  assign q_ready_o   = init_done_q && (!b_valid_q || b_fire);
  assign init_done_o = init_done_q;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.accepted = out_acc_q;

  always_comb begin
    s    = state_q;
    d    = depth_q;
    f    = failed_q;
    acc  = 1'b0;
    s_m1 = '0;
    case (b_op_q)
      dfanc_pkg::OP_BYTE: begin
        if (!f && (s != 7'd0)) begin
          if (b_oob_q) begin
            s = 7'd0;
          end else begin
            s = tt_rdata_q;
            if (cls_rdata_q[0]) begin
              if (d >= DW'(MAX_DEPTH)) begin
                f = 1'b1;
              end else begin
                d = DW'(d + 1'b1);
              end
            end
            if (!f && cls_rdata_q[1]) begin
              if (d == '0) begin
                f = 1'b1;
              end else begin
                d = DW'(d - 1'b1);
              end
            end
          end
        end
        s_m1 = 7'(s - 7'd1);
        acc  = !f && (d == '0) && (s != 7'd0) && mask_q[s_m1[5:0]];
      end
      dfanc_pkg::OP_EMPTY: begin
        acc = 1'b1;
      end
      default: begin
      end
    endcase
    if (b_emit) begin
      s = 7'd1;
      d = '0;
      f = 1'b0;
    end
    state_d  = b_fire ? s : state_q;
    depth_d  = b_fire ? d : depth_q;
    failed_d = b_fire ? f : failed_q;
  end

  always_comb begin
    sym_idx  = q_item_i.symbol[AW-1:0];
    tt_we    = 1'b0;
    tt_re    = 1'b0;
    cls_we   = 1'b0;
    tt_wdata = q_item_i.to_state;
    tt_addr  = {SW'(state_d - 7'd1), sym_idx};
    if (!init_done_q) begin
      tt_we    = 1'b1;
      tt_wdata = 7'd0;
      tt_addr  = clr_idx_q;
    end else if (a_fire) begin
      case (q_item_i.op)
        dfanc_pkg::OP_BYTE: begin
          tt_re = 1'b1;
        end
        dfanc_pkg::OP_TRANS: begin
          tt_we   = 1'b1;
          tt_addr = {SW'(q_item_i.from_state - 7'd1), sym_idx};
        end
        dfanc_pkg::OP_CLASS: begin
          cls_we = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tt_we) begin
      tt_mem[tt_addr] <= tt_wdata;
    end
    if (tt_re) begin
      tt_rdata_q <= tt_mem[tt_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!init_done_q) begin
      cls_mem[clr_idx_q[AW-1:0]] <= 2'b00;
    end else if (cls_we) begin
      cls_mem[sym_idx] <= {q_item_i.pop_flag, q_item_i.push_flag};
    end
    if (tt_re) begin
      cls_rdata_q <= cls_mem[sym_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_op_q   <= q_item_i.op;
      b_last_q <= q_item_i.last_byte;
      b_oob_q  <= q_item_i.sym_oob;
    end
    if (b_fire && b_emit) begin
      out_acc_q <= acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      init_done_q <= 1'b0;
      clr_idx_q   <= '0;
      b_valid_q   <= 1'b0;
      state_q     <= 7'd1;
      depth_q     <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        mask_q <= cfg_i.data;
      end
      if (!init_done_q) begin
        clr_idx_q <= TW'(clr_idx_q + 1'b1);
        if (&clr_idx_q) begin
          init_done_q <= 1'b1;
        end
      end
      if (a_fire) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      state_q  <= state_d;
      depth_q  <= depth_d;
      failed_q <= failed_d;
      if (b_fire && b_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[hdl/dfa_with_nesting_counter.sv]
// Throughput: one beat per cycle unless out_o.ready stalls a closing beat; bounded by
// the single transition-table port. A closing byte or empty-string beat passes through
// the queue write, the table read and the resolve into the output register.
// Reset: all control state clears at once; then a clearing pass zeroes the transition
// table and the class table with in_i.ready low; configuration writes are taken throughout.
module dfa_with_nesting_counter #(
  parameter int NUM_STATES = 64,
  parameter int ALPHABET   = 256,
  parameter int MAX_DEPTH  = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dfanc_in_if.sink     in_i,
  dfanc_cfg_if.sink    cfg_i,
  dfanc_out_if.source  out_o
);

  logic             init_done;
  logic             push_valid, push_ready;
  dfanc_pkg::item_t push_item;
  logic             pop_valid, pop_ready;
  dfanc_pkg::item_t pop_item;

  dfanc_front #(
    .NUM_STATES (NUM_STATES),
    .ALPHABET   (ALPHABET)
  ) u_front (
    .in_i         (in_i),
    .init_done_i  (init_done),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_item_o  (push_item)
  );

  dfanc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  dfanc_back #(
    .NUM_STATES (NUM_STATES),
    .ALPHABET   (ALPHABET),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_item_i    (pop_item),
    .q_ready_o   (pop_ready),
    .init_done_o (init_done),
    .cfg_i       (cfg_i),
    .out_o       (out_o)
  );

endmodule
